// ===== hdl/btd_pkg.sv =====
// ----------------------------------------------------------------------------
// btd_pkg
// Shared widths, angle constants, CORDIC step table and side-band types for
// the bearing / turn / distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btd_pkg;

    // Port field widths
    localparam int W_COORD = 16;
    localparam int W_HEAD  = 15;
    localparam int W_TURN  = 14;
    localparam int W_DIST  = 17;

    // Internal widths
    localparam int W_DIFF  = 17;          // target - start, signed
    localparam int W_ABS   = 16;          // |diff|
    localparam int W_SQ    = 2 * W_ABS;   // one square
    localparam int W_REM   = 34;          // radicand / remainder
    localparam int SQ_BITS = 17;          // root bits, one per stage
    localparam int SQ_LAT  = SQ_BITS + 1; // sum stage plus root stages
    localparam int W_ANG   = 16;          // angle arithmetic, 1/64 degree

    // CORDIC vectoring
    localparam int CX_FRAC  = 12;         // input scale 2^12
    localparam int W_CX     = 32;
    localparam int W_Z      = 26;         // accumulator, 2^-16 degree
    localparam int W_ATAN   = 22;
    localparam int ATAN_LEN = 24;
    localparam int R_LSB    = 10;         // 2^-16 deg -> 1/64 deg
    localparam int W_R      = 13;

    localparam int CORDIC_STAGES_DEF = 16;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    localparam logic [W_ATAN-1:0] ATAN_STEPS [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    localparam logic [W_ANG-1:0] FULL_TURN     = 16'd23040;
    localparam logic [W_ANG-1:0] HALF_TURN     = 16'd11520;
    localparam logic [W_ANG-1:0] QUARTER_TURN  = 16'd5760;
    localparam logic [W_ANG-1:0] THREE_QUARTER = 16'd17280;

    localparam logic signed [W_Z-1:0] ACC_NINETY = 26'sd5898240;
    localparam logic [W_Z-1:0]        ROUND_HALF = 26'd512;

    // Per-beat side band carried alongside the CORDIC / root lanes
    typedef struct packed {
        logic [W_HEAD-1:0] head;
        logic              dx_zero;
        logic              dy_zero;
        logic              dx_neg;
        logic              dy_neg;
    } t_side;

endpackage

// ===== hdl/btd_if.sv =====
// ----------------------------------------------------------------------------
// btd_if
// Valid/ready channels: position pair plus heading in, bearing / turn /
// distance out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface btd_in_if;
    import btd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [W_COORD-1:0] start_x;
    logic signed [W_COORD-1:0] start_y;
    logic signed [W_COORD-1:0] target_x;
    logic signed [W_COORD-1:0] target_y;
    logic [W_HEAD-1:0]         current_heading;

    modport source (
        output valid, start_x, start_y, target_x, target_y, current_heading,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, target_x, target_y, current_heading,
        output ready
    );
endinterface

interface btd_out_if;
    import btd_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_HEAD-1:0] target_bearing;
    logic [W_TURN-1:0] turn_angle;
    logic              turn_left;
    logic [W_DIST-1:0] travel_distance;

    modport source (
        output valid, target_bearing, turn_angle, turn_left, travel_distance,
        input  ready
    );
    modport sink (
        input  valid, target_bearing, turn_angle, turn_left, travel_distance,
        output ready
    );
endinterface

// ===== hdl/bearing_turn_distance_top.sv =====
// ----------------------------------------------------------------------------
// bearing_turn_distance_top
// Pipeline: P0, P1, lane entry, LANE lane stages, F1, F2 and the output
//   register, LANE being the larger of CORDIC_STAGES and 18 (17 root steps
//   plus the sum of squares); LANE is 18 at the default of 16 CORDIC stages.
// Throughput: one beat per cycle unless the pipe is frozen, one CORDIC rotation
//   and one root bit per stage. A stalled output freezes the pipe once the slot ahead of it is full.
// Reset: synchronous, active low; clears all valid bits, data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bearing_turn_distance_top #(
    parameter int CORDIC_STAGES = btd_pkg::CORDIC_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btd_in_if.sink     i_in,
    btd_out_if.source  o_res
);
    import btd_pkg::*;

    localparam int LANE = (CORDIC_STAGES > SQ_LAT) ? CORDIC_STAGES : SQ_LAT;

    logic out_take;
    logic pipe_en;

    // ---------------- stage P0: differences, heading wrap ----------------
    logic                     r_p0_valid;
    logic signed [W_DIFF-1:0] r_p0_dx, r_p0_dy;
    logic [W_HEAD-1:0]        r_p0_head;
    logic signed [W_DIFF-1:0] n_p0_dx, n_p0_dy;
    logic [W_HEAD-1:0]        n_p0_head;
    logic [W_ANG-1:0]         head_wide;
    logic [W_ANG-1:0]         head_wrap;

    // ---------------- stage P1: magnitudes, quadrant flags ----------------
    logic              r_p1_valid;
    logic [W_ABS-1:0]  r_p1_ax, r_p1_ay;
    t_side             r_p1_side;
    logic [W_ABS-1:0]  n_p1_ax, n_p1_ay;
    t_side             n_p1_side;
    logic [W_DIFF-1:0] abs_dx, abs_dy;

    // ---------------- lane: CORDIC rotations and root bits ----------------
    logic                    r_lv   [0:LANE];
    logic signed [W_CX-1:0]  r_cx   [0:LANE];
    logic signed [W_CX-1:0]  r_cy   [0:LANE];
    logic signed [W_Z-1:0]   r_cz   [0:LANE];
    logic [W_REM-1:0]        r_rem  [0:LANE];
    logic [SQ_BITS-1:0]      r_root [0:LANE];
    t_side                   r_side [0:LANE];
    logic [W_SQ-1:0]         r_p2_sq_b;
    logic [W_SQ-1:0]         sq_a, sq_b;

    // ---------------- stage F1: angle rounding, distance rounding ----------
    logic              r_f1_valid;
    logic [W_R-1:0]    r_f1_ang;
    logic [W_DIST-1:0] r_f1_dist;
    t_side             r_f1_side;
    logic [W_R-1:0]    n_f1_ang;
    logic [W_DIST-1:0] n_f1_dist;
    logic signed [W_Z-1:0] z_fin;
    logic [W_Z-1:0]    z_clip;
    logic [W_Z-1:0]    z_rnd;
    logic [W_DIST:0]   root_up;

    // ---------------- stage F2: bearing ----------------
    logic              r_f2_valid;
    logic [W_HEAD-1:0] r_f2_bearing;
    logic [W_HEAD-1:0] r_f2_head;
    logic [W_DIST-1:0] r_f2_dist;
    logic [W_HEAD-1:0] n_f2_bearing;
    logic [W_ANG-1:0]  brg;
    logic [W_ANG-1:0]  brg_wrap;

    // ---------------- output register: turn ----------------
    logic              r_out_valid;
    logic [W_HEAD-1:0] r_out_bearing;
    logic [W_TURN-1:0] r_out_turn;
    logic              r_out_left;
    logic [W_DIST-1:0] r_out_dist;
    logic [W_TURN-1:0] n_out_turn;
    logic              n_out_left;
    logic signed [W_DIFF-1:0] delta;
    logic [W_DIFF-1:0] delta_abs;
    logic [W_ANG-1:0]  mag;
    logic [W_ANG-1:0]  turn_wide;

    // Output slot empty or being drained; an empty F2 also absorbs one beat.
    assign out_take   = !r_out_valid || o_res.ready;
    assign pipe_en    = out_take || !r_f2_valid;
    assign i_in.ready = pipe_en;

    // ======================= P0 =======================
    always_comb begin
        n_p0_dx   = W_DIFF'(i_in.target_x) - W_DIFF'(i_in.start_x);
        n_p0_dy   = W_DIFF'(i_in.target_y) - W_DIFF'(i_in.start_y);
        head_wide = W_ANG'(i_in.current_heading);
        head_wrap = head_wide - FULL_TURN;
        if (head_wide >= FULL_TURN) begin
            n_p0_head = head_wrap[W_HEAD-1:0];
        end else begin
            n_p0_head = i_in.current_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (pipe_en) begin
            r_p0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p0_dx   <= n_p0_dx;
            r_p0_dy   <= n_p0_dy;
            r_p0_head <= n_p0_head;
        end
    end

    // ======================= P1 =======================
    always_comb begin
        abs_dx            = r_p0_dx[W_DIFF-1] ? W_DIFF'(-r_p0_dx) : W_DIFF'(r_p0_dx);
        abs_dy            = r_p0_dy[W_DIFF-1] ? W_DIFF'(-r_p0_dy) : W_DIFF'(r_p0_dy);
        n_p1_ax           = abs_dx[W_ABS-1:0];
        n_p1_ay           = abs_dy[W_ABS-1:0];
        n_p1_side.head    = r_p0_head;
        n_p1_side.dx_zero = (r_p0_dx == '0);
        n_p1_side.dy_zero = (r_p0_dy == '0);
        n_p1_side.dx_neg  = r_p0_dx[W_DIFF-1];
        n_p1_side.dy_neg  = r_p0_dy[W_DIFF-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_p1_valid <= r_p0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p1_ax   <= n_p1_ax;
            r_p1_ay   <= n_p1_ay;
            r_p1_side <= n_p1_side;
        end
    end

    // ======================= P2 (lane entry) =======================
    assign sq_a = r_p1_ax * r_p1_ax;
    assign sq_b = r_p1_ay * r_p1_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else if (pipe_en) begin
            r_lv[0] <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cx[0]   <= $signed(W_CX'({r_p1_ax, CX_FRAC'(0)}));
            r_cy[0]   <= $signed(W_CX'({r_p1_ay, CX_FRAC'(0)}));
            r_cz[0]   <= '0;
            r_rem[0]  <= W_REM'(sq_a);
            r_root[0] <= '0;
            r_p2_sq_b <= sq_b;
            r_side[0] <= r_p1_side;
        end
    end

    // ======================= lane stages =======================
    for (genvar k = 0; k < LANE; k++) begin : g_lane
        logic signed [W_CX-1:0] n_cx, n_cy;
        logic signed [W_Z-1:0]  n_cz;
        logic [W_REM-1:0]       n_rem;
        logic [SQ_BITS-1:0]     n_root;

        if (k < CORDIC_STAGES && k < ATAN_LEN) begin : g_rot
            localparam logic signed [W_Z-1:0] STEP = W_Z'(ATAN_STEPS[k]);
            always_comb begin
                // rotate toward the x axis, steering on the sign of y
                if (!r_cy[k][W_CX-1]) begin
                    n_cx = r_cx[k] + (r_cy[k] >>> k);
                    n_cy = r_cy[k] - (r_cx[k] >>> k);
                    n_cz = r_cz[k] + STEP;
                end else begin
                    n_cx = r_cx[k] - (r_cy[k] >>> k);
                    n_cy = r_cy[k] + (r_cx[k] >>> k);
                    n_cz = r_cz[k] - STEP;
                end
            end
        end else begin : g_rot_hold
            assign n_cx = r_cx[k];
            assign n_cy = r_cy[k];
            assign n_cz = r_cz[k];
        end

        if (k == 0) begin : g_sum
            assign n_rem  = r_rem[k] + W_REM'(r_p2_sq_b);
            assign n_root = '0;
        end else if (k <= SQ_BITS) begin : g_root
            localparam int B = SQ_BITS - k;
            logic [W_REM-1:0] trial;
            // (q + 2^B)^2 - q^2
            assign trial = (W_REM'(r_root[k]) << (B + 1)) + (W_REM'(1) << (2 * B));
            always_comb begin
                if (r_rem[k] >= trial) begin
                    n_rem  = r_rem[k] - trial;
                    n_root = r_root[k] | (SQ_BITS'(1) << B);
                end else begin
                    n_rem  = r_rem[k];
                    n_root = r_root[k];
                end
            end
        end else begin : g_root_hold
            assign n_rem  = r_rem[k];
            assign n_root = r_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k+1] <= 1'b0;
            end else if (pipe_en) begin
                r_lv[k+1] <= r_lv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_cx[k+1]   <= n_cx;
                r_cy[k+1]   <= n_cy;
                r_cz[k+1]   <= n_cz;
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // ======================= F1 =======================
    always_comb begin
        z_fin = r_cz[LANE];
        if (z_fin[W_Z-1]) begin
            z_clip = '0;
        end else if (z_fin > ACC_NINETY) begin
            z_clip = ACC_NINETY;
        end else begin
            z_clip = z_fin;
        end
        z_rnd    = z_clip + ROUND_HALF;
        n_f1_ang = z_rnd[R_LSB+W_R-1:R_LSB];

        // remainder holds s - q^2: round up when it exceeds q
        root_up = {1'b0, r_root[LANE]}
                + (W_DIST+1)'(r_rem[LANE] > W_REM'(r_root[LANE]));
        n_f1_dist = root_up[W_DIST] ? '1 : root_up[W_DIST-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_f1_valid <= r_lv[LANE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_f1_ang  <= n_f1_ang;
            r_f1_dist <= n_f1_dist;
            r_f1_side <= r_side[LANE];
        end
    end

    // ======================= F2 =======================
    always_comb begin
        if (r_f1_side.dx_zero && r_f1_side.dy_zero) begin
            brg = W_ANG'(r_f1_side.head);          // no displacement: keep heading
        end else if (r_f1_side.dx_zero) begin
            brg = r_f1_side.dy_neg ? HALF_TURN : '0;
        end else if (r_f1_side.dy_zero) begin
            brg = r_f1_side.dx_neg ? THREE_QUARTER : QUARTER_TURN;
        end else if (!r_f1_side.dx_neg && !r_f1_side.dy_neg) begin
            brg = QUARTER_TURN - W_ANG'(r_f1_ang);
        end else if (r_f1_side.dx_neg && !r_f1_side.dy_neg) begin
            brg = THREE_QUARTER + W_ANG'(r_f1_ang);
        end else if (r_f1_side.dx_neg) begin
            brg = THREE_QUARTER - W_ANG'(r_f1_ang);
        end else begin
            brg = QUARTER_TURN + W_ANG'(r_f1_ang);
        end
        brg_wrap = brg - FULL_TURN;
        if (brg >= FULL_TURN) begin
            n_f2_bearing = brg_wrap[W_HEAD-1:0];
        end else begin
            n_f2_bearing = brg[W_HEAD-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (pipe_en) begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_f2_bearing <= n_f2_bearing;
            r_f2_head    <= r_f1_side.head;
            r_f2_dist    <= r_f1_dist;
        end
    end

    // ======================= output: turn =======================
    always_comb begin
        delta     = $signed(W_DIFF'(r_f2_bearing)) - $signed(W_DIFF'(r_f2_head));
        delta_abs = delta[W_DIFF-1] ? W_DIFF'(-delta) : W_DIFF'(delta);
        mag       = delta_abs[W_ANG-1:0];
        // exactly +180 goes left, exactly -180 goes right
        if (mag >= HALF_TURN) begin
            turn_wide  = FULL_TURN - mag;
            n_out_left = !delta[W_DIFF-1];
        end else begin
            turn_wide  = mag;
            n_out_left = delta[W_DIFF-1];
        end
        n_out_turn = turn_wide[W_TURN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_bearing <= r_f2_bearing;
            r_out_turn    <= n_out_turn;
            r_out_left    <= n_out_left;
            r_out_dist    <= r_f2_dist;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.target_bearing  = r_out_bearing;
    assign o_res.turn_angle      = r_out_turn;
    assign o_res.turn_left       = r_out_left;
    assign o_res.travel_distance = r_out_dist;

endmodule

// ===== hdl/btd_chk.sv =====
// ----------------------------------------------------------------------------
// btd_chk
// Port-level checks for bearing_turn_distance_top, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btd_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btd_in_if.sink     i_in,
    btd_out_if.source  o_res
);
    import btd_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid
            && $stable(o_res.target_bearing) && $stable(o_res.turn_angle)
            && $stable(o_res.turn_left) && $stable(o_res.travel_distance))
        else $error("output beat changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");

    // an empty output slot never back-pressures the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_in.ready)
        else $error("input stalled with output slot empty");

    a_zero_turn_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.turn_angle == '0) |-> !o_res.turn_left)
        else $error("zero turn reported as left");

    // only coincident points give zero distance, and they keep the heading
    a_zero_dist_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.travel_distance == '0) |-> (o_res.turn_angle == '0))
        else $error("zero distance with nonzero turn");

endmodule

bind bearing_turn_distance_top btd_chk u_btd_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_res   (o_res)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bearing_turn_distance_top. A queue of position
// pairs (directed corners first, then random legs) feeds a valid/ready driver.
// Every accepted beat is run through a local bearing / turn / distance
// calculation, and each output beat is checked field by field, in order.
// Source gaps and sink stalls vary by phase, with one long sink hold-off
// that backs the pipe up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import btd_pkg::*;

    localparam int STAGES      = 16;
    localparam int N_RANDOM    = 500;
    localparam int PHASE_LEN   = 130;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int DIST_MAX    = 131071;

    typedef struct packed {
        logic signed [W_COORD-1:0] from_x;
        logic signed [W_COORD-1:0] from_y;
        logic signed [W_COORD-1:0] to_x;
        logic signed [W_COORD-1:0] to_y;
        logic [W_HEAD-1:0]         heading;
    } t_leg;

    typedef struct packed {
        logic [W_HEAD-1:0] bearing;
        logic [W_TURN-1:0] turn;
        logic              left;
        logic [W_DIST-1:0] travel;
    } t_course;

    logic i_clk;
    logic i_rst_n;

    btd_in_if  in_if ();
    btd_out_if out_if ();

    bearing_turn_distance_top #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (out_if)
    );

    t_leg    legs_pending [$];
    t_course course_due [$];
    int      n_loaded;
    int      n_checked;
    int      n_err;
    int      idle_cycles;
    int      hold_left;
    bit      hold_done;
    int      phase;
    int      send_idle_pct;
    int      recv_stall_pct;

    always #1 i_clk = ~i_clk;

    // phases: free run, sparse source, stalling sink, both
    assign phase = (n_loaded / PHASE_LEN > 3) ? 3 : n_loaded / PHASE_LEN;

    always_comb begin
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    end

    // Bearing from the CORDIC acute angle, shortest turn, rounded root distance
    function automatic t_course plot_course(t_leg leg);
        t_course c;
        int      dx, dy, head, brg, delta, turn, i;
        bit      left;
        longint  ax, ay, x, y, z, xs, ys, sq, root, trial;
        dx   = int'($signed(leg.to_x)) - int'($signed(leg.from_x));
        dy   = int'($signed(leg.to_y)) - int'($signed(leg.from_y));
        head = int'(leg.heading);
        if (head >= int'(FULL_TURN)) head -= int'(FULL_TURN);
        if (dx == 0 && dy == 0) begin
            c.bearing = W_HEAD'(head);
            c.turn    = '0;
            c.left    = 1'b0;
            c.travel  = '0;
            return c;
        end
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0) begin
            brg = (dy > 0) ? 0 : int'(HALF_TURN);
        end else if (dy == 0) begin
            brg = (dx > 0) ? int'(QUARTER_TURN) : int'(THREE_QUARTER);
        end else begin
            x = ax <<< CX_FRAC;
            y = ay <<< CX_FRAC;
            z = 0;
            for (i = 0; i < STAGES && i < ATAN_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_STEPS[i]);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_STEPS[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(ACC_NINETY)) z = longint'(ACC_NINETY);
            z = (z + longint'(ROUND_HALF)) >>> R_LSB;
            if (dx > 0 && dy > 0)      brg = int'(QUARTER_TURN) - int'(z);
            else if (dx < 0 && dy > 0) brg = int'(THREE_QUARTER) + int'(z);
            else if (dx < 0)           brg = int'(THREE_QUARTER) - int'(z);
            else                       brg = int'(QUARTER_TURN) + int'(z);
            if (brg >= int'(FULL_TURN)) brg -= int'(FULL_TURN);
        end
        // exactly +180 goes left, exactly -180 goes right
        delta = brg - head;
        if (delta < 0) begin
            turn = -delta;
            left = 1'b1;
            if (turn >= int'(HALF_TURN)) begin
                turn = int'(FULL_TURN) - turn;
                left = 1'b0;
            end
        end else begin
            turn = delta;
            left = 1'b0;
            if (turn >= int'(HALF_TURN)) begin
                turn = int'(FULL_TURN) - turn;
                left = 1'b1;
            end
        end
        sq   = ax * ax + ay * ay;
        root = 0;
        for (i = 17; i >= 0; i--) begin
            trial = root | (longint'(1) <<< i);
            if (trial * trial <= sq) root = trial;
        end
        if (sq - root * root > root) root++;
        if (root > DIST_MAX) root = DIST_MAX;
        c.bearing = W_HEAD'(brg);
        c.turn    = W_TURN'(turn);
        c.left    = left;
        c.travel  = W_DIST'(root);
        return c;
    endfunction

    task automatic add_leg(int fx, int fy, int tx, int ty, int hd);
        t_leg leg;
        leg.from_x  = fx[W_COORD-1:0];
        leg.from_y  = fy[W_COORD-1:0];
        leg.to_x    = tx[W_COORD-1:0];
        leg.to_y    = ty[W_COORD-1:0];
        leg.heading = hd[W_HEAD-1:0];
        legs_pending.push_back(leg);
    endtask

    task automatic flag_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_err++;
        end
    endtask

    // Source side
    always @(posedge i_clk) begin : drive_legs
        t_leg leg;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            n_loaded    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (legs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                leg = legs_pending.pop_front();
                in_if.start_x         <= leg.from_x;
                in_if.start_y         <= leg.from_y;
                in_if.target_x        <= leg.to_x;
                in_if.target_y        <= leg.to_y;
                in_if.current_heading <= leg.heading;
                in_if.valid           <= 1'b1;
                n_loaded              <= n_loaded + 1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Sink side, with one long hold-off to back up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && n_checked >= 20) begin
            hold_left    = HOLD_CYCLES;
            hold_done    = 1'b1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Prediction on input beats, checking on output beats
    always @(posedge i_clk) begin : check_course
        t_leg    leg;
        t_course want;
        if (!i_rst_n) begin
            n_checked <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (course_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got bearing %0d turn %0d",
                             $time, out_if.target_bearing, out_if.turn_angle);
                    n_err++;
                end else begin
                    want = course_due.pop_front();
                    flag_field("target_bearing", want.bearing, out_if.target_bearing);
                    flag_field("turn_angle", want.turn, out_if.turn_angle);
                    flag_field("turn_left", want.left, out_if.turn_left);
                    flag_field("travel_distance", want.travel, out_if.travel_distance);
                end
                n_checked <= n_checked + 1;
            end
            if (in_if.valid && in_if.ready) begin
                leg.from_x  = in_if.start_x;
                leg.from_y  = in_if.start_y;
                leg.to_x    = in_if.target_x;
                leg.to_y    = in_if.target_y;
                leg.heading = in_if.current_heading;
                course_due.push_back(plot_course(leg));
            end
        end
    end

    // Watchdog: cycles without any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int n, kind, fx, fy, tx, ty, hd, step;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.start_x         = '0;
        in_if.start_y         = '0;
        in_if.target_x        = '0;
        in_if.target_y        = '0;
        in_if.current_heading = '0;
        out_if.ready          = 1'b0;
        n_err                 = 0;
        idle_cycles           = 0;

        // equal points, including an out-of-range heading
        add_leg(0, 0, 0, 0, 100);
        add_leg(-32768, 32767, -32768, 32767, 23039);
        add_leg(1000, -1000, 1000, -1000, 30000);
        // axis-aligned targets
        add_leg(0, 0, 0, 256, 0);
        add_leg(0, 0, 0, -256, 0);          // +180: left
        add_leg(0, 0, 0, 100, 11520);       // -180: right
        add_leg(0, 0, 300, 0, 5760);        // zero turn
        add_leg(0, 0, -300, 0, 0);
        add_leg(0, -32768, 0, 32767, 23040);
        add_leg(-32768, 5, 32767, 5, 17280);
        // coordinate extremes
        add_leg(-32768, -32768, 32767, 32767, 0);
        add_leg(32767, 32767, -32768, -32768, 23039);
        add_leg(32767, -32768, -32768, 32767, 32767);
        add_leg(-32768, 32767, 32767, -32768, 23040);
        add_leg(-32768, -32768, -32767, 32767, 11519);
        add_leg(-32768, -32768, 32767, -32767, 11521);
        // unit steps in each quadrant
        add_leg(0, 0, 1, 1, 0);
        add_leg(0, 0, -1, 1, 0);
        add_leg(0, 0, -1, -1, 0);
        add_leg(0, 0, 1, -1, 0);
        add_leg(0, 0, 0, 1, 23039);         // one step right
        add_leg(5, 5, 7, 6, 1);

        for (n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(99);
            fx   = int'($urandom_range(65535)) - 32768;
            fy   = int'($urandom_range(65535)) - 32768;
            tx   = int'($urandom_range(65535)) - 32768;
            ty   = int'($urandom_range(65535)) - 32768;
            hd   = $urandom_range(int'(FULL_TURN) - 1);
            if (kind < 50) begin
                // full-range legs
            end else if (kind < 68) begin
                fx = int'($urandom_range(60000)) - 30000;
                fy = int'($urandom_range(60000)) - 30000;
                tx = fx + int'($urandom_range(16)) - 8;
                ty = fy + int'($urandom_range(16)) - 8;
            end else if (kind < 80) begin
                if ($urandom_range(1)) tx = fx;
                else                   ty = fy;
                if ($urandom_range(1)) hd = int'(QUARTER_TURN) * int'($urandom_range(3));
            end else if (kind < 85) begin
                tx = fx;
                ty = fy;
            end else if (kind < 93) begin
                fx   = int'($urandom_range(20000)) - 10000;
                fy   = int'($urandom_range(20000)) - 10000;
                step = $urandom_range(1, 20000);
                tx   = $urandom_range(1) ? fx + step : fx - step;
                ty   = $urandom_range(1) ? fy + step : fy - step;
            end else begin
                hd = $urandom_range(int'(FULL_TURN), 32767);
            end
            add_leg(fx, fy, tx, ty, hd);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (legs_pending.size() != 0 || in_if.valid) @(posedge i_clk);
        while (course_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_err == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== bearing_turn_distance_top.f =====
hdl/btd_pkg.sv
hdl/btd_if.sv
hdl/bearing_turn_distance_top.sv
hdl/btd_chk.sv
test/tb_top.sv
